// ===== hdl/spectral_color_classifier_macros.svh =====
// assertion macros for the spectral color classifier checker
`ifndef SPECTRAL_COLOR_CLASSIFIER_MACROS_SVH
`define SPECTRAL_COLOR_CLASSIFIER_MACROS_SVH
`define SCC_ASSERT_IMP(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");
`define SCC_ASSERT_NEXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");
`endif

// ===== hdl/scc_pkg.sv =====
// ----------------------------------------------------------------------------
// scc_pkg
// types and constants shared by the spectral color classifier
// ----------------------------------------------------------------------------
`default_nettype none
package scc_pkg;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_GREEN_MIN_CLEAR  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RED_MIN_CLEAR    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GREEN_SCORE_MIN  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_WHITE_RG_LIMIT   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_WHITE_F4F6_LIMIT = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_RED_RG_MIN       = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_RED_RB_MIN       = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_RED_CLEAR_MIN    = 3'd7;
   localparam logic [1:0] DOM_NONE  = 2'd0;
   localparam logic [1:0] DOM_BLUE  = 2'd1;
   localparam logic [1:0] DOM_GREEN = 2'd2;
   localparam logic [1:0] DOM_RED   = 2'd3;

   typedef struct packed {
      logic        reading_valid;
      logic [15:0] band_one;
      logic [15:0] band_two;
      logic [15:0] band_three;
      logic [15:0] band_four;
      logic [15:0] band_six;
      logic [15:0] band_seven;
      logic [15:0] clear_count;
      logic [15:0] nir_count;
   } req_type;

   typedef struct packed {
      logic        result_valid;
      logic [15:0] intensity;
      logic [16:0] blue_level;
      logic [16:0] green_level;
      logic [16:0] red_level;
      logic [15:0] red_green_ratio;
      logic [15:0] blue_green_ratio;
      logic [15:0] nir_clear_ratio;
      logic [1:0]  dominant_channel;
      logic        green_found;
      logic        red_found;
   } rsp_type;

   typedef struct packed {
      logic [15:0] green_min_clear;
      logic [15:0] red_min_clear;
      logic [8:0]  green_score_min;
      logic [15:0] white_rg_limit;
      logic [15:0] white_f4f6_limit;
      logic [15:0] red_rg_min;
      logic [15:0] red_rb_min;
      logic [15:0] red_clear_min;
   } csr_type;
endpackage
`default_nettype wire

// ===== hdl/scc_divider.sv =====
// ----------------------------------------------------------------------------
// scc_divider
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
`default_nettype none
module scc_divider #(
   parameter int NUM_W = 33,
   parameter int DEN_W = 18,
   parameter int TAG_W = 1
) (
   input  wire logic             clock,
   input  wire logic [NUM_W-1:0] num,
   input  wire logic [DEN_W-1:0] den,
   input  wire logic [TAG_W-1:0] tag_in,
   output logic      [NUM_W-1:0] quot,
   output logic      [TAG_W-1:0] tag_out
);
   // stage k decides quotient bit NUM_W-1-k
   logic [DEN_W:0]   rem_ff [NUM_W];
   logic [NUM_W-1:0] num_ff [NUM_W];
   logic [NUM_W-1:0] q_ff   [NUM_W];
   logic [DEN_W-1:0] den_ff [NUM_W];
   logic [TAG_W-1:0] tag_ff [NUM_W];

   for (genvar k = 0; k < NUM_W; k++) begin : g_stage
      logic [DEN_W:0]   rem_src;
      logic [NUM_W-1:0] num_src;
      logic [NUM_W-1:0] q_src;
      logic [DEN_W-1:0] den_src;
      logic [TAG_W-1:0] tag_src;
      logic [DEN_W+1:0] trial;
      logic             take;
      if (k == 0) begin : g_first
         assign rem_src = '0;
         assign num_src = num;
         assign q_src   = '0;
         assign den_src = den;
         assign tag_src = tag_in;
      end else begin : g_next
         assign rem_src = rem_ff[k-1];
         assign num_src = num_ff[k-1];
         assign q_src   = q_ff[k-1];
         assign den_src = den_ff[k-1];
         assign tag_src = tag_ff[k-1];
      end
      assign trial = {rem_src, num_src[NUM_W-1-k]};
      assign take  = trial >= {2'b00, den_src};
      always_ff @(posedge clock) begin
         if (take) begin
            rem_ff[k] <= (DEN_W+1)'(trial - {2'b00, den_src});
         end else begin
            rem_ff[k] <= trial[DEN_W:0];
         end
         q_ff[k]   <= q_src | (NUM_W'(take) << (NUM_W-1-k));
         num_ff[k] <= num_src;
         den_ff[k] <= den_src;
         tag_ff[k] <= tag_src;
      end
   end

   assign quot    = q_ff[NUM_W-1];
   assign tag_out = tag_ff[NUM_W-1];
endmodule
`default_nettype wire

// ===== hdl/scc_decide.sv =====
// ----------------------------------------------------------------------------
// scc_decide
// green scoring, white check and red thresholds on the divided ratios, registered
// ----------------------------------------------------------------------------
`default_nettype none
module scc_decide
   import scc_pkg::*;
#(
   parameter int FRAC = 8,
   parameter int RW   = 17 + FRAC
) (
   input  wire logic          clock,
   input  wire csr_type       csr,
   input  wire logic          go_green,
   input  wire logic          go_red,
   input  wire logic [RW-1:0] rg,
   input  wire logic [RW-1:0] gb,
   input  wire logic [RW-1:0] ff,
   input  wire logic [RW-1:0] rb,
   input  wire logic [RW-1:0] rc,
   output logic [8:0]         s_rg,
   output logic [8:0]         s_gb,
   output logic [8:0]         s_ff,
   output logic               white,
   output logic               red
);
   localparam longint ONE = 64'd1 << FRAC;
   localparam longint RG_BEST  = (4 * ONE + 2) / 5;
   localparam longint RG_WORST = (29 * ONE + 10) / 20;
   localparam longint GB_BEST  = (9 * ONE + 2) / 5;
   localparam longint GB_WORST = (21 * ONE + 10) / 20;
   localparam longint FF_BEST  = (7 * ONE + 2) / 5;
   localparam longint FF_WORST = (3 * ONE + 2) / 4;
   localparam int     SPAN_W   = FRAC + 2;
   localparam int     REC_W    = SPAN_W + 12;
   localparam int     PROD_W   = SPAN_W + REC_W;
   localparam int     REC_SH   = 8 + 2 * SPAN_W;
   localparam longint RG_SPAN  = RG_WORST - RG_BEST;
   localparam longint GB_SPAN  = GB_BEST - GB_WORST;
   localparam longint FF_SPAN  = FF_BEST - FF_WORST;
   localparam logic [REC_W-1:0] RG_RECIP =
      REC_W'(((64'd1 << REC_SH) + RG_SPAN - 1) / RG_SPAN);
   localparam logic [REC_W-1:0] GB_RECIP =
      REC_W'(((64'd1 << REC_SH) + GB_SPAN - 1) / GB_SPAN);
   localparam logic [REC_W-1:0] FF_RECIP =
      REC_W'(((64'd1 << REC_SH) + FF_SPAN - 1) / FF_SPAN);

   // score = 256*d/span by reciprocal multiplication, exact for d < span
   function automatic logic [8:0] score(input logic [SPAN_W-1:0] d,
                                        input logic [REC_W-1:0] recip);
      logic [PROD_W-1:0] p;
      p = PROD_W'(d) * PROD_W'(recip);
      return 9'(p >> (2 * SPAN_W));
   endfunction

   logic [8:0] rg_s, gb_s, ff_s;
   always_comb begin
      if (rg <= RW'(RG_BEST)) rg_s = 9'd256;
      else if (rg >= RW'(RG_WORST)) rg_s = '0;
      else rg_s = score(SPAN_W'(RW'(RG_WORST) - rg), RG_RECIP);
      if (gb >= RW'(GB_BEST)) gb_s = 9'd256;
      else if (gb <= RW'(GB_WORST)) gb_s = '0;
      else gb_s = score(SPAN_W'(gb - RW'(GB_WORST)), GB_RECIP);
      if (ff >= RW'(FF_BEST)) ff_s = 9'd256;
      else if (ff <= RW'(FF_WORST)) ff_s = '0;
      else ff_s = score(SPAN_W'(ff - RW'(FF_WORST)), FF_RECIP);
   end

   always_ff @(posedge clock) begin
      s_rg  <= go_green ? rg_s : '0;
      s_gb  <= go_green ? gb_s : '0;
      s_ff  <= go_green ? ff_s : '0;
      white <= !go_green || (rg >= RW'(csr.white_rg_limit) && ff <= RW'(csr.white_f4f6_limit));
      red   <= go_red && rg > RW'(csr.red_rg_min) && rb > RW'(csr.red_rb_min)
               && rc > RW'(csr.red_clear_min);
   end
endmodule
`default_nettype wire

// ===== hdl/spectral_color_classifier.sv =====
// ----------------------------------------------------------------------------
// spectral_color_classifier
// color ratios, dominant channel and green/red detection per sensor reading
// ----------------------------------------------------------------------------
// One reading enters per cycle; its result beat appears on rsp_strobe after
// the reading has passed the 18 + RATIO_FRAC_BITS bit-per-stage ratio dividers
// and four register stages. The receiver cannot stall, so every beat taken on
// start comes out exactly once; busy stays low.
`default_nettype none
module spectral_color_classifier
   import scc_pkg::*;
#(
   parameter int RATIO_FRAC_BITS = 8
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire req_type                req_data,
   output logic                        rsp_strobe,
   output rsp_type                     rsp_data,
   input  wire logic                   csr_write,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);
   localparam int F  = RATIO_FRAC_BITS;
   localparam int NW = 18 + F;   // numerator r<<F fits 17+F, clear path too
   localparam int DW = 18;
   localparam int TW = 1 + 16 + 3 * 17 + 2 + 2;

   csr_type csr_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= '{16'd11, 16'd15, 9'd141, 16'd384, 16'd210, 16'd768, 16'd768, 16'd143};
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_GREEN_MIN_CLEAR:  csr_ff.green_min_clear  <= csr_data;
            CSR_RED_MIN_CLEAR:    csr_ff.red_min_clear    <= csr_data;
            CSR_GREEN_SCORE_MIN:  csr_ff.green_score_min  <= csr_data[8:0];
            CSR_WHITE_RG_LIMIT:   csr_ff.white_rg_limit   <= csr_data;
            CSR_WHITE_F4F6_LIMIT: csr_ff.white_f4f6_limit <= csr_data;
            CSR_RED_RG_MIN:       csr_ff.red_rg_min       <= csr_data;
            CSR_RED_RB_MIN:       csr_ff.red_rb_min       <= csr_data;
            CSR_RED_CLEAR_MIN:    csr_ff.red_clear_min    <= csr_data;
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   // stage 0: sums and dominant channel
   logic        v0_ff, gg0_ff, gr0_ff;
   logic [15:0] clr0_ff, nir0_ff, f4_0_ff, f6_0_ff;
   logic [16:0] b0_ff, g0_ff, r0_ff;
   logic [16:0] b_in, g_in, r_in;
   logic        valid_in;
   assign valid_in = start && req_data.reading_valid;
   assign b_in = {1'b0, req_data.band_one} + {1'b0, req_data.band_two};
   assign g_in = {1'b0, req_data.band_three} + {1'b0, req_data.band_four};
   assign r_in = {1'b0, req_data.band_six} + {1'b0, req_data.band_seven};

   always_ff @(posedge clock) begin
      if (reset) v0_ff <= 1'b0;
      else       v0_ff <= valid_in;
      clr0_ff <= valid_in ? req_data.clear_count : '0;
      nir0_ff <= req_data.nir_count;
      f4_0_ff <= req_data.band_four;
      f6_0_ff <= req_data.band_six;
      b0_ff   <= valid_in ? b_in : '0;
      g0_ff   <= valid_in ? g_in : '0;
      r0_ff   <= valid_in ? r_in : '0;
      gg0_ff  <= req_data.clear_count >= csr_ff.green_min_clear && b_in != 0 && g_in != 0
                 && r_in != 0 && req_data.band_six != 0;
      gr0_ff  <= req_data.clear_count >= csr_ff.red_min_clear && b_in != 0 && g_in != 0
                 && r_in != 0 && req_data.clear_count != 0;
   end

   logic [1:0] dom0;
   always_comb begin
      if (b0_ff == 0 && g0_ff == 0 && r0_ff == 0) dom0 = DOM_NONE;
      else if (b0_ff >= g0_ff && b0_ff >= r0_ff)  dom0 = DOM_BLUE;
      else if (g0_ff >= r0_ff)                    dom0 = DOM_GREEN;
      else                                        dom0 = DOM_RED;
   end

   // seven dividers in parallel, one quotient bit per stage
   logic [NW-1:0] q_rg, q_bg, q_nc, q_gb, q_ff, q_rb, q_rc;
   logic [TW-1:0] tag_in, tag_out;
   assign tag_in = {v0_ff, clr0_ff, b0_ff, g0_ff, r0_ff, dom0, gg0_ff & v0_ff, gr0_ff & v0_ff};

   scc_divider #(.NUM_W(NW), .DEN_W(DW), .TAG_W(TW)) u_div_rg (
      .clock, .num(NW'(r0_ff) << F), .den(DW'(g0_ff)), .tag_in, .quot(q_rg), .tag_out);
   scc_divider #(.NUM_W(NW), .DEN_W(DW), .TAG_W(1)) u_div_bg (
      .clock, .num(NW'(b0_ff) << F), .den(DW'(g0_ff)), .tag_in(1'b0), .quot(q_bg),
      .tag_out());
   scc_divider #(.NUM_W(NW), .DEN_W(DW), .TAG_W(1)) u_div_nc (
      .clock, .num(NW'(nir0_ff) << F), .den(DW'(clr0_ff)), .tag_in(1'b0), .quot(q_nc),
      .tag_out());
   scc_divider #(.NUM_W(NW), .DEN_W(DW), .TAG_W(1)) u_div_gb (
      .clock, .num(NW'(g0_ff) << F), .den(DW'(b0_ff)), .tag_in(1'b0), .quot(q_gb),
      .tag_out());
   scc_divider #(.NUM_W(NW), .DEN_W(DW), .TAG_W(1)) u_div_ff (
      .clock, .num(NW'(f4_0_ff) << F), .den(DW'(f6_0_ff)), .tag_in(1'b0), .quot(q_ff),
      .tag_out());
   scc_divider #(.NUM_W(NW), .DEN_W(DW), .TAG_W(1)) u_div_rb (
      .clock, .num(NW'(r0_ff) << F), .den(DW'(b0_ff)), .tag_in(1'b0), .quot(q_rb),
      .tag_out());
   scc_divider #(.NUM_W(NW), .DEN_W(DW), .TAG_W(1)) u_div_rc (
      .clock, .num(NW'(r0_ff) << F), .den({1'b0, clr0_ff, 1'b0}), .tag_in(1'b0),
      .quot(q_rc), .tag_out());

   // valid bit alongside the divider pipe
   logic [NW-1:0] vpipe_ff;
   always_ff @(posedge clock) begin
      if (reset) vpipe_ff <= '0;
      else       vpipe_ff <= {vpipe_ff[NW-2:0], v0_ff};
   end

   function automatic logic [15:0] sat(input logic [NW-1:0] q, input logic z);
      if (z) return '0;
      return (q > NW'(16'hFFFF)) ? 16'hFFFF : q[15:0];
   endfunction

   // stage d1: ratios registered, scoring
   logic        v1_ff, gg1_ff, gr1_ff;
   logic [TW-1:0] tag1_ff;
   logic [NW-1:0] rg1_ff, gb1_ff, ff1_ff, rb1_ff, rc1_ff;
   logic [15:0] o_rg1_ff, o_bg1_ff, o_nc1_ff;
   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else       v1_ff <= vpipe_ff[NW-1];
      tag1_ff  <= tag_out;
      gg1_ff   <= tag_out[1];
      gr1_ff   <= tag_out[0];
      rg1_ff   <= q_rg;
      gb1_ff   <= q_gb;
      ff1_ff   <= q_ff;
      rb1_ff   <= q_rb;
      rc1_ff   <= q_rc;
      o_rg1_ff <= sat(q_rg, tag_out[TW-1-16-1-17 -: 17] == 0);
      o_bg1_ff <= sat(q_bg, tag_out[TW-1-16-1-17 -: 17] == 0);
      o_nc1_ff <= sat(q_nc, tag_out[TW-2 -: 16] == 0);
   end

   logic [8:0] s_rg, s_gb, s_ff;
   logic       white, red2;
   scc_decide #(.FRAC(F), .RW(NW)) u_decide (
      .clock, .csr(csr_ff), .go_green(gg1_ff), .go_red(gr1_ff), .rg(rg1_ff), .gb(gb1_ff),
      .ff(ff1_ff), .rb(rb1_ff), .rc(rc1_ff), .s_rg, .s_gb, .s_ff, .white, .red(red2));

   logic        v2_ff;
   logic [TW-1:0] tag2_ff;
   logic [15:0] o_rg2_ff, o_bg2_ff, o_nc2_ff;
   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else       v2_ff <= v1_ff;
      tag2_ff  <= tag1_ff;
      o_rg2_ff <= o_rg1_ff;
      o_bg2_ff <= o_bg1_ff;
      o_nc2_ff <= o_nc1_ff;
   end

   // stage 3: weighted sum and feature count
   logic [15:0] wsum;
   logic [15:0] wmin;
   logic [1:0]  cnt;
   assign wsum = 16'(16'd40 * s_rg) + 16'(16'd35 * s_gb) + 16'(16'd25 * s_ff);
   assign wmin = 16'(16'd100 * csr_ff.green_score_min);
   assign cnt  = 2'((13'd10 * s_rg) >= 13'd768) + 2'((13'd10 * s_gb) >= 13'd768)
               + 2'((13'd10 * s_ff) >= 13'd768);

   // wsum up to 25600, wmin up to 51100: 16 bits is enough
   rsp_type rsp_ff;
   logic    strobe_ff;
   always_ff @(posedge clock) begin
      if (reset) strobe_ff <= 1'b0;
      else       strobe_ff <= v2_ff;
      rsp_ff.result_valid     <= tag2_ff[TW-1];
      rsp_ff.intensity        <= tag2_ff[TW-2 -: 16];
      rsp_ff.blue_level       <= tag2_ff[TW-18 -: 17];
      rsp_ff.green_level      <= tag2_ff[TW-35 -: 17];
      rsp_ff.red_level        <= tag2_ff[TW-52 -: 17];
      rsp_ff.dominant_channel <= tag2_ff[3:2];
      rsp_ff.red_green_ratio  <= o_rg2_ff;
      rsp_ff.blue_green_ratio <= o_bg2_ff;
      rsp_ff.nir_clear_ratio  <= o_nc2_ff;
      rsp_ff.green_found      <= !white && cnt >= 2'd2 && wsum >= wmin;
      rsp_ff.red_found        <= red2;
   end

   // invalid readings still produce an all-zero beat
   logic [NW+3:0] spipe_ff;
   always_ff @(posedge clock) begin
      if (reset) spipe_ff <= '0;
      else       spipe_ff <= {spipe_ff[NW+2:0], start};
   end

   assign rsp_strobe = spipe_ff[NW+3];
   assign rsp_data   = strobe_ff ? rsp_ff : '0;
endmodule
`default_nettype wire

// ===== hdl/scc_checker.sv =====
// ----------------------------------------------------------------------------
// scc_checker
// port-level checks of the classifier, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none
`include "spectral_color_classifier_macros.svh"
module scc_checker
   import scc_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    busy,
   input wire logic    rsp_strobe,
   input wire rsp_type rsp_data
);
   `SCC_ASSERT_IMP(a_never_busy, clock, reset, 1'b1, !busy)
   `SCC_ASSERT_IMP(a_zero_when_invalid, clock, reset, rsp_strobe && !rsp_data.result_valid,
      rsp_data == '0)
   `SCC_ASSERT_IMP(a_green_zero, clock, reset, rsp_strobe && rsp_data.green_found,
      rsp_data.green_level != 0)
   `SCC_ASSERT_IMP(a_idle_quiet, clock, reset, !rsp_strobe, rsp_data == '0)
endmodule

bind spectral_color_classifier scc_checker u_scc_checker (
   .clock(clock), .reset(reset), .busy(busy), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data));
`default_nettype wire
